// ===== src/spd_pkg.sv =====
`timescale 1ns / 1ps

package spd_pkg;

  localparam int NODES_DEF       = 32;
  localparam int EDGES_DEF       = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int FUNC_W   = 2;
  localparam int NODE_W   = 5;
  localparam int WIN_W    = 16;
  localparam int DIST_W   = 21;
  localparam int PATH_W   = 5;
  localparam int MAX_PATH = 32;
  localparam int CMP_W    = 7;

  localparam logic [DIST_W-1:0] DIST_SAT = 21'd2097151;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RLX_ADDR,
    ST_RLX_EDGE,
    ST_RLX_CMP,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== src/spd_ram.sv =====
`timescale 1ns / 1ps

module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spd_ctrl.sv =====
`timescale 1ns / 1ps

module spd_ctrl #(
  parameter int NODES       = spd_pkg::NODES_DEF,
  parameter int EDGES       = spd_pkg::EDGES_DEF,
  parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF,
  localparam int NB = $clog2(NODES),
  localparam int EA = (EDGES > 1) ? $clog2(EDGES) : 1,
  localparam int DB = WEIGHT_BITS + NB,
  localparam int NW = 1 + NB + DB,
  localparam int EW = 2 * spd_pkg::NODE_W + WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spd_pkg::FUNC_W-1:0]    in_func,
  input  logic [spd_pkg::NODE_W-1:0]    in_edge_from,
  input  logic [spd_pkg::NODE_W-1:0]    in_edge_to,
  input  logic [spd_pkg::WIN_W-1:0]     in_weight,
  input  logic [spd_pkg::NODE_W-1:0]    in_source,
  input  logic [spd_pkg::NODE_W-1:0]    in_target,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_reachable,
  output logic [spd_pkg::DIST_W-1:0]    out_distance,
  output logic [spd_pkg::PATH_W-1:0]    out_path_node,
  output logic [spd_pkg::PATH_W-1:0]    out_path_index,
  output logic                          out_last,
  output logic                          out_edges_dropped,
  output logic                          e_we,
  output logic [EA-1:0]                 e_waddr,
  output logic [EW-1:0]                 e_wdata,
  output logic [EA-1:0]                 e_raddr,
  input  logic [EW-1:0]                 e_rdata,
  output logic                          n_we,
  output logic [NB-1:0]                 n_waddr,
  output logic [NW-1:0]                 n_wdata,
  output logic [NB-1:0]                 n_raddr,
  input  logic [NW-1:0]                 n_rdata
);

  localparam int CB = $clog2(EDGES + 1);
  localparam int PB = spd_pkg::PATH_W;
  localparam int PC = PB + 1;
  localparam int CW = spd_pkg::CMP_W;
  localparam int NWD = spd_pkg::NODE_W;

  spd_pkg::state_t state_r, state_nxt;

  logic [CB-1:0]      edge_cnt_r, edge_cnt_nxt;
  logic               drop_r, drop_nxt;
  logic [NB-1:0]      src_r, src_nxt;
  logic [NB-1:0]      tgt_r, tgt_nxt;
  logic [NODES-1:0]   reached_r, reached_nxt;
  logic [NODES-1:0]   settled_r, settled_nxt;
  logic [NB:0]        scan_r, scan_nxt;
  logic               found_r, found_nxt;
  logic [NB-1:0]      best_r, best_nxt;
  logic [DB-1:0]      best_d_r, best_d_nxt;
  logic [NB-1:0]      u_r, u_nxt;
  logic [DB-1:0]      du_r, du_nxt;
  logic [CB-1:0]      e_r, e_nxt;
  logic [NB-1:0]      v_r, v_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [NB-1:0]      n_r, n_nxt;
  logic               first_r, first_nxt;
  logic [DB-1:0]      tdist_r, tdist_nxt;
  logic [NB-1:0]      stack_r [spd_pkg::MAX_PATH];
  logic [NB-1:0]      stack_nxt [spd_pkg::MAX_PATH];
  logic [PC-1:0]      pcnt_r, pcnt_nxt;
  logic [PC-1:0]      k_r, k_nxt;
  logic               unreach_r, unreach_nxt;

  logic                       ov_r, ov_nxt;
  logic                       oreach_r, oreach_nxt;
  logic [spd_pkg::DIST_W-1:0] odist_r, odist_nxt;
  logic [PB-1:0]              onode_r, onode_nxt;
  logic [PB-1:0]              oidx_r, oidx_nxt;
  logic                       olast_r, olast_nxt;
  logic                       odrop_r, odrop_nxt;

  logic               accept;
  logic [NB-1:0]      prev_idx;
  logic               cand;
  logic               f_any;
  logic [NB-1:0]      f_idx;
  logic [DB-1:0]      f_d;
  logic [DB-1:0]      rd_dist;
  logic               rd_pv;
  logic [NB-1:0]      rd_pred;
  logic [NWD-1:0]     ed_src;
  logic [NWD-1:0]     ed_dst;
  logic [WEIGHT_BITS-1:0] ed_w;
  logic [DB-1:0]      nd;
  logic               last_edge;
  logic               out_free;
  logic [spd_pkg::DIST_W-1:0] dist_out;
  logic [PC-1:0]      k_pos;

  assign in_stall = (state_r != spd_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_dist  = n_rdata[DB-1:0];
  assign rd_pred  = n_rdata[NW-2:DB];
  assign rd_pv    = n_rdata[NW-1];
  assign ed_src   = e_rdata[EW-1 -: NWD];
  assign ed_dst   = e_rdata[EW-NWD-1 -: NWD];
  assign ed_w     = e_rdata[WEIGHT_BITS-1:0];
  assign nd       = du_r + DB'(w_r);
  assign last_edge = ((e_r + CB'(1)) == edge_cnt_r);
  assign out_free = !ov_r || !out_stall;
  assign prev_idx = NB'(scan_r - (NB+1)'(1));
  assign cand     = (scan_r != '0) && reached_r[prev_idx] && !settled_r[prev_idx] &&
                    (!found_r || (rd_dist < best_d_r));
  assign f_any    = found_r || cand;
  assign f_idx    = cand ? prev_idx : best_r;
  assign f_d      = cand ? rd_dist : best_d_r;
  assign k_pos    = pcnt_r - PC'(1) - k_r;

  always_comb begin
    if ((DB > spd_pkg::DIST_W) && (tdist_r > DB'(spd_pkg::DIST_SAT))) begin
      dist_out = spd_pkg::DIST_SAT;
    end else begin
      dist_out = spd_pkg::DIST_W'(tdist_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= spd_pkg::ST_IDLE;
      edge_cnt_r <= '0;
      drop_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      drop_r     <= drop_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    tgt_r     <= tgt_nxt;
    reached_r <= reached_nxt;
    settled_r <= settled_nxt;
    scan_r    <= scan_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    best_d_r  <= best_d_nxt;
    u_r       <= u_nxt;
    du_r      <= du_nxt;
    e_r       <= e_nxt;
    v_r       <= v_nxt;
    w_r       <= w_nxt;
    n_r       <= n_nxt;
    first_r   <= first_nxt;
    tdist_r   <= tdist_nxt;
    stack_r   <= stack_nxt;
    pcnt_r    <= pcnt_nxt;
    k_r       <= k_nxt;
    unreach_r <= unreach_nxt;
    oreach_r  <= oreach_nxt;
    odist_r   <= odist_nxt;
    onode_r   <= onode_nxt;
    oidx_r    <= oidx_nxt;
    olast_r   <= olast_nxt;
    odrop_r   <= odrop_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    edge_cnt_nxt = edge_cnt_r;
    drop_nxt     = drop_r;
    src_nxt      = src_r;
    tgt_nxt      = tgt_r;
    reached_nxt  = reached_r;
    settled_nxt  = settled_r;
    scan_nxt     = scan_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_d_nxt   = best_d_r;
    u_nxt        = u_r;
    du_nxt       = du_r;
    e_nxt        = e_r;
    v_nxt        = v_r;
    w_nxt        = w_r;
    n_nxt        = n_r;
    first_nxt    = first_r;
    tdist_nxt    = tdist_r;
    stack_nxt    = stack_r;
    pcnt_nxt     = pcnt_r;
    k_nxt        = k_r;
    unreach_nxt  = unreach_r;
    ov_nxt       = ov_r && out_stall;
    oreach_nxt   = oreach_r;
    odist_nxt    = odist_r;
    onode_nxt    = onode_r;
    oidx_nxt     = oidx_r;
    olast_nxt    = olast_r;
    odrop_nxt    = odrop_r;
    e_we         = 1'b0;
    e_waddr      = edge_cnt_r[EA-1:0];
    e_wdata      = {in_edge_from, in_edge_to, WEIGHT_BITS'(in_weight)};
    e_raddr      = e_r[EA-1:0];
    n_we         = 1'b0;
    n_waddr      = v_r;
    n_wdata      = {1'b1, u_r, nd};
    n_raddr      = n_r;

    unique case (state_r)
      spd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            spd_pkg::FUNC_CLEAR: begin
              edge_cnt_nxt = '0;
              drop_nxt     = 1'b0;
            end
            spd_pkg::FUNC_ADD: begin
              if (edge_cnt_r >= CB'(EDGES)) begin
                drop_nxt = 1'b1;
              end else begin
                e_we         = 1'b1;
                edge_cnt_nxt = edge_cnt_r + CB'(1);
              end
            end
            spd_pkg::FUNC_QUERY: begin
              src_nxt     = NB'(in_source);
              tgt_nxt     = NB'(in_target);
              unreach_nxt = 1'b0;
              k_nxt       = '0;
              if ((CW'(in_source) >= CW'(NODES)) || (CW'(in_target) >= CW'(NODES))) begin
                unreach_nxt = 1'b1;
                state_nxt   = spd_pkg::ST_EMIT;
              end else begin
                state_nxt = spd_pkg::ST_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      spd_pkg::ST_INIT: begin
        n_we        = 1'b1;
        n_waddr     = src_r;
        n_wdata     = '0;
        reached_nxt = '0;
        reached_nxt[src_r] = 1'b1;
        settled_nxt = '0;
        scan_nxt    = '0;
        found_nxt   = 1'b0;
        pcnt_nxt    = '0;
        first_nxt   = 1'b1;
        state_nxt   = spd_pkg::ST_SCAN;
      end
      spd_pkg::ST_SCAN: begin
        n_raddr    = scan_r[NB-1:0];
        found_nxt  = f_any;
        best_nxt   = f_idx;
        best_d_nxt = f_d;
        if (scan_r == (NB+1)'(NODES)) begin
          scan_nxt  = '0;
          found_nxt = 1'b0;
          if (f_any) begin
            settled_nxt[f_idx] = 1'b1;
            u_nxt  = f_idx;
            du_nxt = f_d;
            e_nxt  = '0;
            if (edge_cnt_r != '0) begin
              state_nxt = spd_pkg::ST_RLX_ADDR;
            end
          end else if (reached_r[tgt_r]) begin
            n_nxt     = tgt_r;
            state_nxt = spd_pkg::ST_WALK_RD;
          end else begin
            unreach_nxt = 1'b1;
            state_nxt   = spd_pkg::ST_EMIT;
          end
        end else begin
          scan_nxt = scan_r + (NB+1)'(1);
        end
      end
      spd_pkg::ST_RLX_ADDR: begin
        state_nxt = spd_pkg::ST_RLX_EDGE;
      end
      spd_pkg::ST_RLX_EDGE: begin
        v_nxt   = NB'(ed_dst);
        w_nxt   = ed_w;
        n_raddr = NB'(ed_dst);
        if ((CW'(ed_src) == CW'(u_r)) && (CW'(ed_dst) < CW'(NODES))) begin
          state_nxt = spd_pkg::ST_RLX_CMP;
        end else if (last_edge) begin
          state_nxt = spd_pkg::ST_SCAN;
        end else begin
          e_nxt     = e_r + CB'(1);
          state_nxt = spd_pkg::ST_RLX_ADDR;
        end
      end
      spd_pkg::ST_RLX_CMP: begin
        if (!reached_r[v_r] || (nd < rd_dist)) begin
          n_we             = 1'b1;
          reached_nxt[v_r] = 1'b1;
        end
        if (last_edge) begin
          state_nxt = spd_pkg::ST_SCAN;
        end else begin
          e_nxt     = e_r + CB'(1);
          state_nxt = spd_pkg::ST_RLX_ADDR;
        end
      end
      spd_pkg::ST_WALK_RD: begin
        state_nxt = spd_pkg::ST_WALK_WAIT;
      end
      spd_pkg::ST_WALK_WAIT: begin
        first_nxt = 1'b0;
        if (first_r) begin
          tdist_nxt = rd_dist;
        end
        stack_nxt[pcnt_r[PB-1:0]] = n_r;
        pcnt_nxt = pcnt_r + PC'(1);
        if (!rd_pv || ((pcnt_r + PC'(1)) >= PC'(spd_pkg::MAX_PATH))) begin
          state_nxt = spd_pkg::ST_EMIT;
        end else begin
          n_nxt     = rd_pred;
          state_nxt = spd_pkg::ST_WALK_RD;
        end
      end
      spd_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          odrop_nxt = drop_r;
          if (unreach_r) begin
            oreach_nxt = 1'b0;
            odist_nxt  = '0;
            onode_nxt  = '0;
            oidx_nxt   = '0;
            olast_nxt  = 1'b1;
            state_nxt  = spd_pkg::ST_IDLE;
          end else begin
            oreach_nxt = 1'b1;
            odist_nxt  = dist_out;
            onode_nxt  = PB'(stack_r[k_pos[PB-1:0]]);
            oidx_nxt   = k_r[PB-1:0];
            olast_nxt  = (k_pos == '0);
            k_nxt      = k_r + PC'(1);
            if (k_pos == '0) begin
              state_nxt = spd_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = spd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid         = ov_r;
  assign out_reachable     = oreach_r;
  assign out_distance      = odist_r;
  assign out_path_node     = onode_r;
  assign out_path_index    = oidx_r;
  assign out_last          = olast_r;
  assign out_edges_dropped = odrop_r;

  a_settled_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spd_pkg::ST_SCAN) |-> ((settled_r & ~reached_r) == '0))
    else $error("settled node not reached");

  a_source_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spd_pkg::ST_INIT) |=> reached_r[src_r])
    else $error("source not reached after init");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    edge_cnt_r <= CB'(EDGES))
    else $error("edge count over capacity");

  a_unreach_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !oreach_r) |-> olast_r)
    else $error("unreachable result not last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spd_pkg::ST_EMIT && out_free && (unreach_r || k_pos == '0))
    |=> (state_r == spd_pkg::ST_IDLE))
    else $error("query did not finish after last result");

endmodule

// ===== src/shortest_path_dijkstra.sv =====
`timescale 1ns / 1ps

// shortest path engine over a stored directed edge list
// input channel: in_valid / in_stall, one transaction per command
//   func clear: empties the edge list and the drop flag
//   func add: appends one edge; a full list sets edges_dropped
//   func query: runs Dijkstra from in_source toward in_target
// result channel: out_valid / out_stall, one transaction per path node from
//   source to target with out_last on the final one, or a single
//   unreachable transaction; clear and add give no result
// query steps: per settled node one scan of all nodes plus one pass over
//   the stored edges, with an extra compare step when the edge leaves the
//   settled node, then a walk of the predecessor chain from the target and
//   one emit step per result; the run time is set by the single read ports
//   of the node and edge memories
// in_stall is high for the whole query; the next command is taken once the
//   last result sits in the output register
// a stalled receiver holds the output register and freezes the emit step
// reset clears the edge count, the drop flag and the output valid; the edge
//   and node memories need no clearing

module shortest_path_dijkstra #(
  parameter int NODES       = spd_pkg::NODES_DEF,
  parameter int EDGES       = spd_pkg::EDGES_DEF,
  parameter int WEIGHT_BITS = spd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spd_pkg::FUNC_W-1:0]  in_func,
  input  logic [spd_pkg::NODE_W-1:0]  in_edge_from,
  input  logic [spd_pkg::NODE_W-1:0]  in_edge_to,
  input  logic [spd_pkg::WIN_W-1:0]   in_weight,
  input  logic [spd_pkg::NODE_W-1:0]  in_source,
  input  logic [spd_pkg::NODE_W-1:0]  in_target,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_reachable,
  output logic [spd_pkg::DIST_W-1:0]  out_distance,
  output logic [spd_pkg::PATH_W-1:0]  out_path_node,
  output logic [spd_pkg::PATH_W-1:0]  out_path_index,
  output logic                        out_last,
  output logic                        out_edges_dropped
);

  localparam int NB = $clog2(NODES);
  localparam int EA = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int DB = WEIGHT_BITS + NB;
  localparam int NW = 1 + NB + DB;
  localparam int EW = 2 * spd_pkg::NODE_W + WEIGHT_BITS;

  logic          e_we;
  logic [EA-1:0] e_waddr;
  logic [EW-1:0] e_wdata;
  logic [EA-1:0] e_raddr;
  logic [EW-1:0] e_rdata;
  logic          n_we;
  logic [NB-1:0] n_waddr;
  logic [NW-1:0] n_wdata;
  logic [NB-1:0] n_raddr;
  logic [NW-1:0] n_rdata;

  spd_ram #(.WIDTH(EW), .DEPTH(EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  spd_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  spd_ctrl #(
    .NODES       (NODES),
    .EDGES       (EDGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_weight         (in_weight),
    .in_source         (in_source),
    .in_target         (in_target),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reachable     (out_reachable),
    .out_distance      (out_distance),
    .out_path_node     (out_path_node),
    .out_path_index    (out_path_index),
    .out_last          (out_last),
    .out_edges_dropped (out_edges_dropped),
    .e_we              (e_we),
    .e_waddr           (e_waddr),
    .e_wdata           (e_wdata),
    .e_raddr           (e_raddr),
    .e_rdata           (e_rdata),
    .n_we              (n_we),
    .n_waddr           (n_waddr),
    .n_wdata           (n_wdata),
    .n_raddr           (n_raddr),
    .n_rdata           (n_rdata)
  );

endmodule
